// File: rtl/core/wfd_pkg.sv
// wfd_pkg: shared types and constants for the websocket frame deframer
// used by wfd_front, wfd_queue, wfd_back and the top level
package wfd_pkg;

  localparam logic [7:0] FIN_MASK    = 8'h80;
  localparam logic [6:0] LEN_MASK    = 7'h7f;
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  // header byte counts at which an extended length is complete
  localparam logic [3:0] HDR_END_16 = 4'd4;
  localparam logic [3:0] HDR_END_64 = 4'd10;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // one operation handed from the parser to the output side
  typedef struct packed {
    logic       is_byte;  // 1: payload word, 0: end of an empty final frame
    logic       last;     // payload word closes the message
    logic [7:0] data;
  } wfd_op_t;

endpackage

// File: rtl/core/wfd_front.sv
// wfd_front: header parser, tracks frame length and classifies each word
// depends on wfd_pkg
module wfd_front #(
  parameter int LENGTH_WIDTH = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  logic [7:0]      rx_byte,
  output logic            push,
  output wfd_pkg::wfd_op_t op
);
  import wfd_pkg::*;

  logic [3:0]              cnt_r, cnt_nxt;
  logic                    done_r, done_nxt;
  logic                    final_r, final_nxt;
  logic                    len64_r, len64_nxt;
  logic [LENGTH_WIDTH-1:0] rem_r, rem_nxt;
  logic [6:0]              code;
  logic                    frame_clr;

  assign code = rx_byte[6:0] & LEN_MASK;

  always_comb begin
    cnt_nxt   = cnt_r;
    done_nxt  = done_r;
    final_nxt = final_r;
    len64_nxt = len64_r;
    rem_nxt   = rem_r;
    push      = 1'b0;
    op        = '0;
    frame_clr = 1'b0;
    if (fire) begin
      if (done_r) begin
        push       = 1'b1;
        op.is_byte = 1'b1;
        op.data    = rx_byte;
        op.last    = final_r && (rem_r == LENGTH_WIDTH'(1));
        rem_nxt    = rem_r - LENGTH_WIDTH'(1);
        frame_clr  = (rem_r == LENGTH_WIDTH'(1));
      end else if (cnt_r == 4'd0) begin
        final_nxt = |(rx_byte & FIN_MASK);
        cnt_nxt   = 4'd1;
      end else begin
        if (cnt_r == 4'd1) begin
          cnt_nxt   = 4'd2;
          rem_nxt   = '0;
          len64_nxt = (code == LEN_CODE_64);
          if (code < LEN_CODE_16) begin
            rem_nxt  = {{(LENGTH_WIDTH-7){1'b0}}, code};
            done_nxt = 1'b1;
          end
        end else begin
          // extended length, saturating when it would not fit
          if (|rem_r[LENGTH_WIDTH-1 -: 8]) begin
            rem_nxt = '1;
          end else begin
            rem_nxt = {rem_r[LENGTH_WIDTH-9:0], rx_byte};
          end
          cnt_nxt = cnt_r + 4'd1;
          if ((!len64_r && cnt_nxt >= HDR_END_16) ||
              (len64_r && cnt_nxt >= HDR_END_64)) begin
            done_nxt = 1'b1;
          end
        end
        if (done_nxt && rem_nxt == '0) begin
          frame_clr = 1'b1;
          if (final_r) begin
            push = 1'b1;
          end
        end
      end
    end
    if (frame_clr) begin
      cnt_nxt   = 4'd0;
      done_nxt  = 1'b0;
      final_nxt = 1'b0;
      len64_nxt = 1'b0;
      rem_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= 4'd0;
      done_r  <= 1'b0;
      final_r <= 1'b0;
      len64_r <= 1'b0;
      rem_r   <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
      final_r <= final_nxt;
      len64_r <= len64_nxt;
      rem_r   <= rem_nxt;
    end
  end

endmodule

// File: rtl/core/wfd_queue.sv
// wfd_queue: short fifo of parsed operations between parser and output side
// depends on wfd_pkg
module wfd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  wfd_pkg::wfd_op_t push_op,
  input  logic             pop,
  output wfd_pkg::wfd_op_t pop_op,
  output logic             full,
  output logic             empty
);
  import wfd_pkg::*;

  wfd_op_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full   = (cnt_r == QCNT_W'(QDEPTH));
  assign empty  = (cnt_r == '0);
  assign pop_op = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

// File: rtl/core/wfd_back.sv
// wfd_back: output register and message length counter
// depends on wfd_pkg
module wfd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  wfd_pkg::wfd_op_t q_op,
  output logic             pop,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [7:0]       out_payload_byte,
  output logic             out_byte_valid,
  output logic             out_message_end,
  output logic [31:0]      out_message_length
);
  import wfd_pkg::*;

  logic        valid_r;
  logic [7:0]  byte_r;
  logic        bv_r, end_r;
  logic [31:0] len_r;
  logic [31:0] total_r, total_nxt, total_inc;

  assign pop       = !q_empty && (!valid_r || !out_stall);
  assign total_inc = (&total_r) ? total_r : total_r + 32'd1;

  always_comb begin
    total_nxt = total_r;
    if (pop) begin
      if (q_op.is_byte) begin
        total_nxt = q_op.last ? 32'd0 : total_inc;
      end else begin
        total_nxt = 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      total_r <= 32'd0;
    end else begin
      total_r <= total_nxt;
      if (pop) begin
        valid_r <= 1'b1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (q_op.is_byte) begin
        byte_r <= q_op.data;
        bv_r   <= 1'b1;
        end_r  <= q_op.last;
        len_r  <= q_op.last ? total_inc : 32'd0;
      end else begin
        byte_r <= 8'd0;
        bv_r   <= 1'b0;
        end_r  <= 1'b1;
        len_r  <= total_r;
      end
    end
  end

  assign out_valid          = valid_r;
  assign out_payload_byte   = byte_r;
  assign out_byte_valid     = bv_r;
  assign out_message_end    = end_r;
  assign out_message_length = len_r;

endmodule

// File: rtl/core/websocket_frame_deframer.sv
// websocket_frame_deframer: top level, parser front, operation queue, output back
// depends on wfd_pkg, wfd_front, wfd_queue, wfd_back
//
// Input channel: one received stream byte per word on in_rx_byte, taken when
// in_valid is high and in_stall low. Header words (FIN/opcode byte, length
// code, 16 or 64 bit big-endian extended length) give no output word.
// Output channel: each payload byte comes out as one word with
// out_byte_valid set; the last byte of a final frame also carries
// out_message_end and the saturating 32-bit message length. A final frame
// with no payload gives one word with out_byte_valid low and out_message_end
// high. Lengths wider than LENGTH_WIDTH saturate.
// Throughput: one byte per cycle while in_stall is low; the parser keeps all
// frame state in single registers updated each cycle. The parser writes the
// two-entry queue at the accepting edge, and the queue then loads the output
// register, which drives out_valid, once that register is empty or not stalled.
// When the receiver stalls, the output word holds, up to two words wait in
// the queue, and in_stall is high while the queue is full. Synchronous reset
// drops any partial frame and message count and empties the queue.
module websocket_frame_deframer #(
  parameter int LENGTH_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_payload_byte,
  output logic        out_byte_valid,
  output logic        out_message_end,
  output logic [31:0] out_message_length
);
  import wfd_pkg::*;

  logic    fire, push, pop, q_full, q_empty;
  wfd_op_t push_op, pop_op;

  assign in_stall = q_full;
  assign fire     = in_valid && !q_full;

  wfd_front #(.LENGTH_WIDTH(LENGTH_WIDTH)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .rx_byte (in_rx_byte),
    .push    (push),
    .op      (push_op)
  );

  wfd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .pop_op  (pop_op),
    .full    (q_full),
    .empty   (q_empty)
  );

  wfd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_op               (pop_op),
    .pop                (pop),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_payload_byte   (out_payload_byte),
    .out_byte_valid     (out_byte_valid),
    .out_message_end    (out_message_end),
    .out_message_length (out_message_length)
  );

endmodule

// File: rtl/core/wfd_checker.sv
// wfd_checker: port-level checks for websocket_frame_deframer
// bound to the top level below; sees ports only
module wfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_payload_byte,
  input logic        out_byte_valid,
  input logic        out_message_end,
  input logic [31:0] out_message_length
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_payload_byte) &&
      $stable(out_message_end) && $stable(out_message_length))
    else $error("stalled output word changed");

  // a word without payload only marks the end of an empty final frame
  a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_message_end && out_payload_byte == 8'd0)
    else $error("empty word without message end");

  // length is only reported at message end
  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_message_end |-> out_message_length == 32'd0)
    else $error("length outside message end");

  // a message ending on a payload byte has at least that byte
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_valid && out_message_end |-> out_message_length != 32'd0)
    else $error("zero length on final payload word");

endmodule

bind websocket_frame_deframer wfd_checker u_wfd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_payload_byte   (out_payload_byte),
  .out_byte_valid     (out_byte_valid),
  .out_message_end    (out_message_end),
  .out_message_length (out_message_length)
);

// File: tb/sv/websocket_frame_deframer_tb.sv
// websocket_frame_deframer_tb: self-checking bench for the websocket frame deframer
// drives framed byte streams, predicts payload and message-end words, compares field by field
// depends on wfd_pkg and websocket_frame_deframer
`timescale 1ns / 1ps

module websocket_frame_deframer_tb;
  import wfd_pkg::*;

  localparam int LW         = 64;
  localparam int QUIET_MAX  = 4000;
  localparam int HOLD_LEN   = 150;
  localparam int MAX_REPORT = 10;

  typedef struct packed {
    logic [7:0]  data;
    logic        is_byte;
    logic        last;
    logic [31:0] length;
  } rx_result_t;

  typedef enum {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_payload_byte;
  logic        out_byte_valid;
  logic        out_message_end;
  logic [31:0] out_message_length;

  // parser state mirrored from the block
  logic [3:0]    hdr_cnt = '0;
  logic          hdr_done = 1'b0;
  logic          frame_fin = 1'b0;
  logic [6:0]    len_code = '0;
  logic [LW-1:0] remaining = '0;
  logic [31:0]   msg_total = '0;

  logic [7:0] rx_stream[$];
  rx_result_t due_words[$];

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_ask = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int mismatches = 0;
  int quiet = 0;

  websocket_frame_deframer #(.LENGTH_WIDTH(LW)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_payload_byte   (out_payload_byte),
    .out_byte_valid     (out_byte_valid),
    .out_message_end    (out_message_end),
    .out_message_length (out_message_length)
  );

  always #6 clk = ~clk;

  task automatic clear_frame();
    hdr_cnt = '0;
    hdr_done = 1'b0;
    frame_fin = 1'b0;
    len_code = '0;
    remaining = '0;
  endtask

  // advance the mirrored parser by one stream byte and queue any word it yields
  task automatic parse_rx_byte(input logic [7:0] b);
    rx_result_t w;
    logic [LW-1:0] lim;
    lim = '1;
    w = '0;
    if (hdr_done) begin
      if (msg_total != 32'hFFFF_FFFF) msg_total = msg_total + 1;
      if (remaining != 0) remaining = remaining - 1;
      w.data = b;
      w.is_byte = 1'b1;
      if (remaining == 0) begin
        if (frame_fin) begin
          w.last = 1'b1;
          w.length = msg_total;
          msg_total = '0;
        end
        clear_frame();
      end
      due_words.push_back(w);
    end else if (hdr_cnt == 0) begin
      frame_fin = (b & FIN_MASK) != 0;
      hdr_cnt = 4'd1;
    end else begin
      if (hdr_cnt == 1) begin
        len_code = b[6:0] & LEN_MASK;
        hdr_cnt = 4'd2;
        remaining = '0;
        if (len_code < LEN_CODE_16) begin
          remaining = LW'(len_code);
          hdr_done = 1'b1;
        end
      end else begin
        // extended length saturates once another byte would overflow
        if (remaining > (lim >> 8)) remaining = lim;
        else remaining = {remaining[LW-9:0], b};
        hdr_cnt = hdr_cnt + 4'd1;
        if ((len_code == LEN_CODE_16 && hdr_cnt >= HDR_END_16) ||
            (len_code == LEN_CODE_64 && hdr_cnt >= HDR_END_64))
          hdr_done = 1'b1;
      end
      if (hdr_done && remaining == 0) begin
        if (frame_fin) begin
          w.last = 1'b1;
          w.length = msg_total;
          msg_total = '0;
          due_words.push_back(w);
        end
        clear_frame();
      end
    end
  endtask

  task automatic push_frame(input bit fin_bit, input int unsigned len, input len_form_t form);
    logic [63:0] l64;
    logic        mask;
    l64 = 64'(len);
    mask = $urandom_range(1);
    // rsv bits and opcode are random, the block ignores them
    rx_stream.push_back({fin_bit, 7'($urandom_range(127))});
    case (form)
      LEN_SHORT: rx_stream.push_back({mask, l64[6:0]});
      LEN_EXT16: begin
        rx_stream.push_back({mask, LEN_CODE_16});
        rx_stream.push_back(l64[15:8]);
        rx_stream.push_back(l64[7:0]);
      end
      default: begin
        rx_stream.push_back({mask, LEN_CODE_64});
        for (int i = 7; i >= 0; i--) rx_stream.push_back(l64[i*8 +: 8]);
      end
    endcase
    repeat (len) rx_stream.push_back(8'($urandom_range(255)));
  endtask

  task automatic push_random_frames(input int nbytes);
    int          start;
    int unsigned r;
    int unsigned len;
    bit          fin_bit;
    len_form_t   form;
    start = rx_stream.size();
    while (rx_stream.size() - start < nbytes) begin
      r = $urandom_range(99);
      if (r < 15) len = 0;
      else if (r < 85) len = $urandom_range(12, 1);
      else if (r < 95) len = $urandom_range(125, 13);
      else len = $urandom_range(300, 126);
      fin_bit = ($urandom_range(99) < 60);
      r = $urandom_range(99);
      if (len >= 126) begin
        if (r < 50) form = LEN_EXT16;
        else form = LEN_EXT64;
      end else if (r < 70) begin
        form = LEN_SHORT;
      end else if (r < 85) begin
        form = LEN_EXT16;
      end else begin
        form = LEN_EXT64;
      end
      push_frame(fin_bit, len, form);
    end
  endtask

  task automatic drain_stream();
    while (rx_stream.size() != 0) @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) parse_rx_byte(in_rx_byte);
      if (!in_valid || !in_stall) begin
        if (rx_stream.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_valid <= 1'b1;
          in_rx_byte <= rx_stream.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin : monitor
    rx_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_words.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORT)
            $display("%0t: unexpected word: byte %02h valid %b end %b len %0d", $realtime,
                     out_payload_byte, out_byte_valid, out_message_end, out_message_length);
        end else begin
          want = due_words.pop_front();
          if (want.data !== out_payload_byte || want.is_byte !== out_byte_valid ||
              want.last !== out_message_end || want.length !== out_message_length) begin
            mismatches++;
            if (mismatches <= MAX_REPORT) begin
              $write("%0t: mismatch: expected byte %02h valid %b end %b len %0d,",
                     $realtime, want.data, want.is_byte, want.last, want.length);
              $display(" got byte %02h valid %b end %b len %0d",
                       out_payload_byte, out_byte_valid, out_message_end,
                       out_message_length);
            end
          end
        end
      end
      // a long hold-off lets the queue fill and back up into in_stall
      if (hold_ask != hold_seen) begin
        hold_seen <= hold_ask;
        hold_left <= HOLD_LEN;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_MAX) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty final frame, empty non-final frame with mask bit
    rx_stream.push_back(8'h81); rx_stream.push_back(8'h00);
    rx_stream.push_back(8'h01); rx_stream.push_back(8'h80);
    // fragment of two, then 16-bit length continuation that ends the message
    rx_stream.push_back(8'h01); rx_stream.push_back(8'h02);
    rx_stream.push_back(8'h00); rx_stream.push_back(8'hFF);
    rx_stream.push_back(8'h80); rx_stream.push_back(8'hFE);
    rx_stream.push_back(8'h00); rx_stream.push_back(8'h01); rx_stream.push_back(8'h5A);
    // non-final with 64-bit length one, then empty final carrying the total
    rx_stream.push_back(8'h0F); rx_stream.push_back(8'h7F);
    repeat (7) rx_stream.push_back(8'h00);
    rx_stream.push_back(8'h01); rx_stream.push_back(8'hA5);
    rx_stream.push_back(8'h88); rx_stream.push_back(8'h00);
    drain_stream();

    idle_pct = 0; stall_pct = 0;
    push_random_frames(180);
    repeat (5) @(negedge clk);
    hold_ask = hold_ask + 1;
    drain_stream();

    idle_pct = 79; stall_pct = 0;
    push_random_frames(140);
    drain_stream();

    idle_pct = 0; stall_pct = 79;
    push_random_frames(140);
    drain_stream();

    idle_pct = 12; stall_pct = 12;
    push_random_frames(140);
    // length that saturates and never completes, followed by payload
    rx_stream.push_back(8'h82); rx_stream.push_back(8'h7F);
    repeat (8) rx_stream.push_back(8'hFF);
    repeat (20) rx_stream.push_back(8'($urandom_range(255)));
    drain_stream();

    while (in_valid || due_words.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0 && due_words.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
